// ===== hdl/tle_pkg.sv =====
// Shared types and float helpers for the tanh-by-limit-exponential unit.
// No dependencies; imported by every module of the block.
package tle_pkg;

	// Port words.
	typedef struct packed {
		logic [31:0] x_bits;
		logic        last_in;
	} in_word_t;

	typedef struct packed {
		logic [31:0] y_bits;
		logic        last_out;
	} out_word_t;

	// Internal normal float: value = man * 2^(ex-23), man[23] set except in a zero numerator (num_zero).
	typedef struct packed {
		logic              sgn;
		logic signed [8:0] ex;
		logic [23:0]       man;
	} fp_t;

	// Exponential pair leaving the squaring chain.
	typedef struct packed {
		logic last;
		fp_t  ep;
		fp_t  en;
	} expo_word_t;

	// Numerator and denominator leaving the add/subtract stages.
	typedef struct packed {
		logic last;
		logic num_zero;
		fp_t  num;
		fp_t  den;
	} frac_word_t;

	localparam int SQ_STEPS = 10;
	localparam int QUO_BITS = 26;
	localparam logic [30:0] LIM_MAG = 31'h41F0_0000; // 30.0
	localparam logic [23:0] LIM_MAN = 24'hF0_0000;
	localparam logic signed [8:0] LIM_EX = 9'sd4;
	localparam logic [7:0] TINY_EXP = 8'd97;          // below 2^-30 the sum rounds to 1
	localparam logic [7:0] SHIFT_BASE = 8'd96;
	localparam logic [65:0] ACC_ONE = {2'b01, 64'd0};
	localparam logic [23:0] MAN_ONE = 24'h80_0000;
	localparam logic signed [8:0] EX_BIAS = 9'sd127;

	// Round to nearest even and renormalize on carry out.
	function automatic fp_t round_pack(logic sgn, logic signed [8:0] e, logic [23:0] m,
		logic r, logic s);
		fp_t        f;
		logic [24:0] mr;
		mr = {1'b0, m} + {24'd0, r & (s | m[0])};
		f.sgn = sgn;
		if (mr[24]) begin
			f.man = mr[24:1];
			f.ex  = e + 9'sd1;
		end else begin
			f.man = mr[23:0];
			f.ex  = e;
		end
		return f;
	endfunction

	// Round the fixed-point 1 + v/1024 (64 fraction bits) to single precision.
	function automatic fp_t acc_round(logic [65:0] t, logic tiny);
		fp_t f;
		if (tiny) begin
			f.sgn = 1'b0;
			f.ex  = 9'sd0;
			f.man = MAN_ONE;
		end else if (t[64]) begin
			f = round_pack(1'b0, 9'sd0, t[64:41], t[40], |t[39:0]);
		end else begin
			f = round_pack(1'b0, -9'sd1, t[63:40], t[39], |t[38:0]);
		end
		return f;
	endfunction

	// One rounded squaring of a positive normal value.
	function automatic fp_t sq_round(fp_t a);
		logic [47:0]       p;
		fp_t               f;
		logic signed [8:0] e2;
		p  = a.man * a.man;
		e2 = a.ex <<< 1;
		if (p[47]) begin
			f = round_pack(1'b0, e2 + 9'sd1, p[47:24], p[23], |p[22:0]);
		end else begin
			f = round_pack(1'b0, e2, p[46:23], p[22], |p[21:0]);
		end
		return f;
	endfunction

endpackage

// ===== hdl/tanh_by_limit_exponential_unit.sv =====
// Top level of the tanh-by-limit-exponential unit.
// Depends on tle_pkg, tle_expo, tle_sumdiff and tle_div.
//
// Streams single-precision words and returns an approximate tanh for each,
// one word per clock. The input is clamped to [-30, 30] (NaN becomes +30),
// e^v and e^-v are formed as (1 + v/1024)^1024 by ten rounded squarings,
// and the result is (ep - en) / (ep + en), every step rounded to nearest
// even as single precision. The last flag rides along unchanged. The path
// is a fixed pipeline of 44 stages: 3 for clamp and 1 + v/1024, 10 for the
// squarings, 3 for the add/subtract, 27 for the quotient (a load stage,
// then one bit per stage) and 1 for rounding, and a new word can be
// taken every cycle. A stall on the result side while a word waits
// there freezes the whole pipeline in place and is passed back to the
// source in the same cycle; nothing is dropped or repeated.
module tanh_by_limit_exponential_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  tle_pkg::in_word_t   src_word,
	output logic                dst_valid,
	input  logic                dst_stall,
	output tle_pkg::out_word_t  dst_word
);
	import tle_pkg::*;

	logic       adv;
	logic       expo_valid, frac_valid;
	expo_word_t expo_word;
	frac_word_t frac_word;

	// Advance unless a finished word is held by the sink.
	assign adv       = !(dst_valid && dst_stall);
	assign src_stall = !adv;

	tle_expo u_expo (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (src_valid),
		.in_word   (src_word),
		.out_valid (expo_valid),
		.out_word  (expo_word)
	);

	tle_sumdiff u_sumdiff (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (expo_valid),
		.in_word   (expo_word),
		.out_valid (frac_valid),
		.out_word  (frac_word)
	);

	tle_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (frac_valid),
		.in_word   (frac_word),
		.out_valid (dst_valid),
		.out_word  (dst_word)
	);
endmodule

// ===== hdl/tle_expo.sv =====
// Clamp, decode and (1 + v/1024)^1024 for v and -v: three front stages
// plus ten rounded squaring stages. Depends on tle_pkg.
module tle_expo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tle_pkg::in_word_t   in_word,
	output logic                out_valid,
	output tle_pkg::expo_word_t out_word
);
	import tle_pkg::*;

	logic [7:0]  exp8;
	logic        is_nan;
	logic        is_big;
	logic        neg_s1, tiny_s1, last_s1, valid_s1;
	logic [23:0] man_s1;
	logic [5:0]  sh_s1;
	logic [65:0] mag;
	logic [65:0] tp_s2, tn_s2;
	logic        tiny_s2, last_s2, valid_s2;
	fp_t         ep_sq [0:SQ_STEPS];
	fp_t         en_sq [0:SQ_STEPS];
	logic        last_sq [0:SQ_STEPS];
	logic        valid_sq [0:SQ_STEPS];

	assign exp8   = in_word.x_bits[30:23];
	assign is_nan = (exp8 == 8'hFF) && (in_word.x_bits[22:0] != 23'd0);
	assign is_big = in_word.x_bits[30:0] >= LIM_MAG;

	// Stage 1: clamp; NaN takes the upper limit.
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= in_word.last_in;
			if (is_nan || is_big) begin
				neg_s1  <= in_word.x_bits[31] & ~is_nan;
				tiny_s1 <= 1'b0;
				man_s1  <= LIM_MAN;
				sh_s1   <= 6'(LIM_EX + 9'sd31);
			end else begin
				neg_s1  <= in_word.x_bits[31];
				tiny_s1 <= exp8 < TINY_EXP;
				man_s1  <= {1'b1, in_word.x_bits[22:0]};
				sh_s1   <= 6'(exp8 - SHIFT_BASE);
			end
		end
	end

	assign mag = {42'd0, man_s1} << sh_s1;

	// Stage 2: exact 1 + v/1024 and 1 - v/1024.
	always_ff @(posedge clk) begin
		if (en) begin
			tp_s2   <= neg_s1 ? ACC_ONE - mag : ACC_ONE + mag;
			tn_s2   <= neg_s1 ? ACC_ONE + mag : ACC_ONE - mag;
			tiny_s2 <= tiny_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: round both sums.
	always_ff @(posedge clk) begin
		if (en) begin
			ep_sq[0]   <= acc_round(tp_s2, tiny_s2);
			en_sq[0]   <= acc_round(tn_s2, tiny_s2);
			last_sq[0] <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_sq[0] <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_sq[0] <= valid_s2;
		end
	end

	// Squaring stages.
	for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sq
		always_ff @(posedge clk) begin
			if (en) begin
				ep_sq[i]   <= sq_round(ep_sq[i-1]);
				en_sq[i]   <= sq_round(en_sq[i-1]);
				last_sq[i] <= last_sq[i-1];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sq[i] <= 1'b0;
			end else if (en) begin
				valid_sq[i] <= valid_sq[i-1];
			end
		end
	end

	assign out_valid     = valid_sq[SQ_STEPS];
	assign out_word.last = last_sq[SQ_STEPS];
	assign out_word.ep   = ep_sq[SQ_STEPS];
	assign out_word.en   = en_sq[SQ_STEPS];
endmodule

// ===== hdl/tle_sumdiff.sv =====
// Rounded ep - en and ep + en in three stages: align, add, normalize/round.
// Depends on tle_pkg.
module tle_sumdiff (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tle_pkg::expo_word_t in_word,
	output logic                out_valid,
	output tle_pkg::frac_word_t out_word
);
	import tle_pkg::*;

	logic        swap;
	fp_t         big, lesser;
	logic [8:0]  gap;
	logic [50:0] wide;
	fp_t         big_s1;
	logic [26:0] sm_s1;
	logic        swap_s1, last_s1, valid_s1;
	fp_t         big_s2;
	logic [27:0] sum_s2;
	logic [26:0] diff_s2;
	logic        swap_s2, last_s2, valid_s2;
	logic [4:0]  lz;
	logic [26:0] normd;
	fp_t         num_s3, den_s3;
	logic        zero_s3, last_s3, valid_s3;

	// Exponents are signed: compare them as such, then the mantissas.
	assign swap   = (in_word.en.ex > in_word.ep.ex) ||
		((in_word.en.ex == in_word.ep.ex) && (in_word.en.man > in_word.ep.man));
	assign big    = swap ? in_word.en : in_word.ep;
	assign lesser = swap ? in_word.ep : in_word.en;
	assign gap    = 9'(big.ex - lesser.ex);
	assign wide   = {lesser.man, 27'd0} >> gap;

	// Stage 1: align the smaller operand with guard, round and sticky.
	always_ff @(posedge clk) begin
		if (en) begin
			big_s1  <= big;
			swap_s1 <= swap;
			last_s1 <= in_word.last;
			if (gap >= 9'd27) begin
				sm_s1 <= 27'd1;
			end else begin
				sm_s1 <= {wide[50:25], |wide[24:0]};
			end
		end
	end

	// Stage 2: add and subtract.
	always_ff @(posedge clk) begin
		if (en) begin
			big_s2  <= big_s1;
			swap_s2 <= swap_s1;
			last_s2 <= last_s1;
			sum_s2  <= {1'b0, big_s1.man, 3'd0} + {1'b0, sm_s1};
			diff_s2 <= {big_s1.man, 3'd0} - sm_s1;
		end
	end

	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (diff_s2[i]) begin
				lz = 5'(26 - i);
			end
		end
	end

	assign normd = diff_s2 << lz;

	// Stage 3: normalize and round.
	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= last_s2;
			zero_s3 <= diff_s2 == 27'd0;
			num_s3  <= round_pack(swap_s2, big_s2.ex - 9'(lz), normd[26:3], normd[2],
				|normd[1:0]);
			if (sum_s2[27]) begin
				den_s3 <= round_pack(1'b0, big_s2.ex + 9'sd1, sum_s2[27:4], sum_s2[3],
					|sum_s2[2:0]);
			end else begin
				den_s3 <= round_pack(1'b0, big_s2.ex, sum_s2[26:3], sum_s2[2],
					|sum_s2[1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid         = valid_s3;
	assign out_word.last     = last_s3;
	assign out_word.num_zero = zero_s3;
	assign out_word.num      = num_s3;
	assign out_word.den      = den_s3;
endmodule

// ===== hdl/tle_div.sv =====
// Correctly rounded num / den: one restoring quotient bit per stage, then
// a rounding and packing stage. Depends on tle_pkg.
module tle_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tle_pkg::frac_word_t in_word,
	output logic                out_valid,
	output tle_pkg::out_word_t  out_word
);
	import tle_pkg::*;

	typedef struct packed {
		logic              sgn;
		logic              zero;
		logic              last;
		logic signed [8:0] ex;
		logic [23:0]       dm;
		logic [24:0]       rem;
		logic [QUO_BITS-1:0] q;
	} div_t;

	div_t  st [0:QUO_BITS];
	logic  vld [0:QUO_BITS];
	fp_t   res;
	logic [8:0] biased;
	logic [31:0] y_s1;
	logic  last_s1, valid_s1;

	// Load stage.
	always_ff @(posedge clk) begin
		if (en) begin
			st[0].sgn  <= in_word.num.sgn;
			st[0].zero <= in_word.num_zero;
			st[0].last <= in_word.last;
			st[0].ex   <= in_word.num.ex - in_word.den.ex;
			st[0].dm   <= in_word.den.man;
			st[0].rem  <= {1'b0, in_word.num.man};
			st[0].q    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
		end
	end

	for (genvar i = 1; i <= QUO_BITS; i++) begin : g_bit
		logic        ge;
		logic [24:0] left;
		assign ge   = st[i-1].rem >= {1'b0, st[i-1].dm};
		assign left = ge ? st[i-1].rem - {1'b0, st[i-1].dm} : st[i-1].rem;
		always_ff @(posedge clk) begin
			if (en) begin
				st[i].sgn  <= st[i-1].sgn;
				st[i].zero <= st[i-1].zero;
				st[i].last <= st[i-1].last;
				st[i].ex   <= st[i-1].ex;
				st[i].dm   <= st[i-1].dm;
				st[i].rem  <= {left[23:0], 1'b0};
				st[i].q    <= {st[i-1].q[QUO_BITS-2:0], ge};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i] <= 1'b0;
			end else if (en) begin
				vld[i] <= vld[i-1];
			end
		end
	end

	always_comb begin
		if (st[QUO_BITS].q[QUO_BITS-1]) begin
			res = round_pack(st[QUO_BITS].sgn, st[QUO_BITS].ex, st[QUO_BITS].q[25:2],
				st[QUO_BITS].q[1], st[QUO_BITS].q[0] | (st[QUO_BITS].rem != 25'd0));
		end else begin
			res = round_pack(st[QUO_BITS].sgn, st[QUO_BITS].ex - 9'sd1,
				st[QUO_BITS].q[24:1], st[QUO_BITS].q[0], st[QUO_BITS].rem != 25'd0);
		end
	end

	assign biased = 9'(res.ex + EX_BIAS);

	// Round and pack; a zero numerator gives +0.
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= st[QUO_BITS].last;
			y_s1    <= st[QUO_BITS].zero ? 32'd0 : {res.sgn, biased[7:0], res.man[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vld[QUO_BITS];
		end
	end

	assign out_valid         = valid_s1;
	assign out_word.y_bits   = y_s1;
	assign out_word.last_out = last_s1;
endmodule

// ===== test/tb_tanh_by_limit_exponential_unit.sv =====
// Self-checking testbench for tanh_by_limit_exponential_unit.
// Depends on tle_pkg for the port word types and LIM_MAG; predicts each word not
// fixed by the table with an integer-exact single-precision model of clamp, (1 + v/1024)^1024 and divide.
module tb_tanh_by_limit_exponential_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tle_pkg::*;

	localparam int LATENCY    = 44;
	localparam int HOLD_LEN   = 300;
	localparam int ITEMS_RAND = 1900;
	localparam int MAX_REPORT = 10;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	in_word_t  src_word;
	logic      dst_valid;
	logic      dst_stall;
	out_word_t dst_word;

	tanh_by_limit_exponential_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_word(dst_word)
	);

	// Words still owed by the pipeline, oldest first.
	out_word_t tanh_owed[$];

	int n_errors;
	int n_sent;
	int n_seen;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_left;
	bit hold_request;

	// Clock: 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net: end the run if the pipeline wedges.
	initial begin
		#2ms;
		$display("timeout: %0d words sent, %0d received", n_sent, n_seen);
		$display("tb_tanh_by_limit_exponential_unit: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Single-precision arithmetic on exact integers.
	// A value is sign, mantissa m and exponent e: (-1)^s * m * 2^e.
	// ------------------------------------------------------------------

	function automatic void fp_unpack(input logic [31:0] b, output logic s,
		output logic [127:0] m, output int e);
		s = b[31];
		if (b[30:23] == 8'd0) begin
			m = {105'd0, b[22:0]};
			e = -149;
		end else begin
			m = {104'd0, 1'b1, b[22:0]};
			e = int'(b[30:23]) - 150;
		end
	endfunction

	// Round an exact value to nearest even, subnormals included.
	function automatic logic [31:0] fp_pack(logic s, logic [127:0] m, int e);
		int           msb;
		int           sh;
		int           ex;
		logic [127:0] k;
		logic         rb;
		logic         st;
		if (m == 128'd0)
			return {s, 31'd0};
		msb = 0;
		for (int i = 0; i < 128; i++)
			if (m[i])
				msb = i;
		sh = msb - 23;
		if (sh < -149 - e)
			sh = -149 - e;
		if (sh > 0) begin
			k  = m >> sh;
			rb = m[sh-1];
			st = (m & ((128'd1 << (sh - 1)) - 128'd1)) != 128'd0;
			if (rb && (st || k[0]))
				k = k + 128'd1;
		end else begin
			k = m << (-sh);
		end
		// Rounding carried into a new bit: renormalize.
		if (k[24]) begin
			k  = k >> 1;
			sh = sh + 1;
		end
		if (!k[23])
			return {s, 8'd0, k[22:0]};
		ex = e + sh + 150;
		return {s, ex[7:0], k[22:0]};
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic         sa, sb;
		logic [127:0] ma, mb;
		int           ea, eb;
		fp_unpack(a, sa, ma, ea);
		fp_unpack(b, sb, mb, eb);
		return fp_pack(sa ^ sb, ma * mb, ea + eb);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic         sa, sb;
		logic [127:0] ma, mb;
		int           ea, eb;
		int           d;
		fp_unpack(a, sa, ma, ea);
		fp_unpack(b, sb, mb, eb);
		if (mb == 128'd0)
			return a;
		if (ma == 128'd0)
			return b;
		if (eb > ea) begin
			{sa, sb} = {sb, sa};
			{ma, mb} = {mb, ma};
			{ea, eb} = {eb, ea};
		end
		d = ea - eb;
		// Far below the rounding point the small operand only acts as sticky.
		if (d > 60) begin
			mb = 128'd1;
			eb = ea - 60;
			d  = 60;
		end
		ma = ma << d;
		if (sa == sb)
			return fp_pack(sa, ma + mb, eb);
		if (ma == mb)
			return 32'd0;
		if (ma > mb)
			return fp_pack(sa, ma - mb, eb);
		return fp_pack(sb, mb - ma, eb);
	endfunction

	function automatic logic [31:0] fp_div(logic [31:0] n, logic [31:0] d);
		logic         sn, sd;
		logic [127:0] mn, md, q, r;
		int           en, ed;
		fp_unpack(n, sn, mn, en);
		fp_unpack(d, sd, md, ed);
		if (mn == 128'd0)
			return {sn ^ sd, 31'd0};
		q = (mn << 61) / md;
		r = (mn << 61) % md;
		return fp_pack(sn ^ sd, {q[126:0], 1'b0} | {127'd0, r != 128'd0}, en - ed - 62);
	endfunction

	// (1 + v/1024)^1024 by ten rounded squarings.
	function automatic logic [31:0] limit_exp(logic [31:0] v);
		logic [31:0] acc;
		acc = fp_add(32'h3F80_0000, fp_mul(v, 32'h3A80_0000));
		for (int k = 0; k < 10; k++)
			acc = fp_mul(acc, acc);
		return acc;
	endfunction

	function automatic out_word_t tanh_predict(in_word_t w);
		logic [31:0] v;
		logic [31:0] ep, en;
		out_word_t   r;
		// NaN goes to +30; magnitudes at or past 30 saturate with their sign.
		if (w.x_bits[30:23] == 8'hFF && w.x_bits[22:0] != 23'd0)
			v = 32'h41F0_0000;
		else if (w.x_bits[30:0] >= LIM_MAG)
			v = {w.x_bits[31], LIM_MAG};
		else
			v = w.x_bits;
		ep = limit_exp(v);
		en = limit_exp({~v[31], v[30:0]});
		r.y_bits   = fp_div(fp_add(ep, {~en[31], en[30:0]}), fp_add(ep, en));
		r.last_out = w.last_in;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------

	// Offer one word; gaps come first, then hold it until taken.
	task automatic send_word(in_word_t w, bit fixed, logic [31:0] y_fixed);
		out_word_t exp_w;
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < sender_idle_pct)
				src_valid <= 1'b0;
			else
				break;
		end
		src_valid <= 1'b1;
		src_word  <= w;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		exp_w = tanh_predict(w);
		if (fixed)
			exp_w.y_bits = y_fixed;
		tanh_owed.push_back(exp_w);
		n_sent++;
	endtask

	// Random operand: mostly inside the clamp, plus raw patterns, tiny
	// values and the area around the saturation point.
	function automatic logic [31:0] pick_operand();
		int          sel;
		logic [7:0]  ex;
		sel = $urandom_range(99);
		if (sel < 55) begin
			ex = 8'($urandom_range(131, 100));
			return {1'($urandom), ex, 23'($urandom)};
		end else if (sel < 75) begin
			return $urandom;
		end else if (sel < 87) begin
			ex = 8'($urandom_range(105, 0));
			return {1'($urandom), ex, 23'($urandom)};
		end else begin
			return {1'($urandom), LIM_MAG + 31'($urandom_range(64)) - 31'd32};
		end
	endfunction

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		in_word_t w;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			w.x_bits  = pick_operand();
			w.last_in = 1'($urandom);
			send_word(w, 1'b0, 32'd0);
		end
	endtask

	typedef struct {
		logic [31:0] x;
		logic        last;
		bit          fixed;
		logic [31:0] y;
	} dir_row_t;

	// Zeros and values too small to move 1 + v/1024 give +0 outright; other rows are predicted.
	dir_row_t dir_tab[23] = '{
		'{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
		'{32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},
		'{32'h8000_0001, 1'b1, 1'b1, 32'h0000_0000},
		'{32'h0080_0000, 1'b0, 1'b1, 32'h0000_0000},
		'{32'h807F_FFFF, 1'b0, 1'b1, 32'h0000_0000},
		'{32'h3F80_0000, 1'b1, 1'b0, 32'h0},
		'{32'hBF80_0000, 1'b0, 1'b0, 32'h0},
		'{32'h41F0_0000, 1'b0, 1'b0, 32'h0},
		'{32'hC1F0_0000, 1'b1, 1'b0, 32'h0},
		'{32'h41EF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'hC1EF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h7F80_0000, 1'b1, 1'b0, 32'h0},
		'{32'hFF80_0000, 1'b0, 1'b0, 32'h0},
		'{32'h7FC0_0000, 1'b0, 1'b0, 32'h0},
		'{32'hFFC0_0000, 1'b1, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
		'{32'h7F7F_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'hFF7F_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'h3F00_0000, 1'b0, 1'b0, 32'h0},
		'{32'hC020_0000, 1'b1, 1'b0, 32'h0},
		'{32'h3A80_0000, 1'b0, 1'b0, 32'h0},
		'{32'h3727_C5AC, 1'b0, 1'b0, 32'h0}
	};

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Check every taken result word against the oldest owed one.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			n_seen++;
			if (tanh_owed.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORT)
					$display("unexpected word y=%h last=%b", dst_word.y_bits,
						dst_word.last_out);
			end else begin
				want = tanh_owed.pop_front();
				if (dst_word.y_bits !== want.y_bits ||
						dst_word.last_out !== want.last_out) begin
					n_errors++;
					if (n_errors <= MAX_REPORT)
						$display("mismatch #%0d: y exp %h got %h, last exp %b got %b",
							n_seen, want.y_bits, dst_word.y_bits,
							want.last_out, dst_word.last_out);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		in_word_t w;
		n_errors           = 0;
		n_sent             = 0;
		n_seen             = 0;
		hold_left          = 0;
		hold_request       = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		arst_n             = 1'b0;
		src_valid          = 1'b0;
		src_word           = '0;
		dst_stall          = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words, back to back.
		foreach (dir_tab[i]) begin
			w.x_bits  = dir_tab[i].x;
			w.last_in = dir_tab[i].last;
			send_word(w, dir_tab[i].fixed, dir_tab[i].y);
		end

		// Full rate, then a long receiver hold-off while words keep coming.
		run_phase(0, 0, 300);
		hold_request = 1'b1;
		run_phase(0, 0, 175);
		run_phase(74, 0, 475);
		run_phase(0, 74, 475);
		run_phase(12, 12, ITEMS_RAND - 1425);

		// Drain: release the source and wait for the last owed word.
		@(negedge clk);
		src_valid <= 1'b0;
		while (tanh_owed.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 16) @(posedge clk);

		$display("sent %0d words (directed edges, NaN, infinities, subnormals, clamp)",
			n_sent);
		$display("received %0d, across full-rate, idle, stall and hold-off phases", n_seen);
		if (n_errors == 0 && tanh_owed.size() == 0) begin
			$display("tb_tanh_by_limit_exponential_unit: done, clean");
		end else begin
			$display("%0d mismatches, %0d words never arrived", n_errors, tanh_owed.size());
			$display("tb_tanh_by_limit_exponential_unit: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tle_pkg.sv
hdl/tle_expo.sv
hdl/tle_sumdiff.sv
hdl/tle_div.sv
hdl/tanh_by_limit_exponential_unit.sv
test/tb_tanh_by_limit_exponential_unit.sv
